// File: hw/rtl/tkwst_pkg.sv
// Shared constants and types for the tag weight stability tracker.
package tkwst_pkg;

    // Default sizing
    localparam int TABLE_ENTRIES_DEF = 20;
    localparam int RING_DEPTH_DEF    = 5;

    // Field widths
    localparam int TAG_W    = 40;
    localparam int WEIGHT_W = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STAB_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAVE_DELTA     = 1'd1;

    // Configuration reset values in grams
    localparam logic [CFG_W-1:0] STAB_THRESHOLD_RESET = 16'd10;
    localparam logic [CFG_W-1:0] SAVE_DELTA_RESET     = 16'd100;

    // Result status codes
    typedef enum logic [1:0] {
        ST_KNOWN = 2'd0,
        ST_NEW   = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

// File: hw/rtl/tkwst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tkwst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 20,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/tkwst_absdiff.sv
// Shared absolute-difference and threshold compare unit.
module tkwst_absdiff (
    input  logic [tkwst_pkg::WEIGHT_W-1:0] a,
    input  logic [tkwst_pkg::WEIGHT_W-1:0] b,
    input  logic [tkwst_pkg::CFG_W-1:0]    limit,
    output logic                           above,
    output logic                           reach
);

    logic [tkwst_pkg::WEIGHT_W-1:0] diff;

    // Take the magnitude of the difference, then compare against the limit
    assign diff  = (a > b) ? (a - b) : (b - a);
    assign above = (diff > limit);
    assign reach = (diff >= limit);

endmodule

// File: hw/rtl/tag_keyed_weight_stability_tracker.sv
// Top level of the tag weight stability tracker: sequencer, tables and result register.
//
// One transaction at a time: a tag is accepted on the slave stream, looked up in
// the tag memory one entry per cycle, registered if new (unless the table is full), and its weight is written
// into that tag's ring of RING_DEPTH samples. When the ring is full, each sample
// is read back in turn and compared with physical ring slot 0 through one shared
// absolute-difference unit, which then also decides whether slot 0 becomes the new
// saved weight. The time an item takes grows with the entries searched and with
// whether the full ring is checked, set by the serial tag search and the single read
// port of the sample memory. The result waits in an output register, so the next
// transaction is taken while it is still unread. Memories need no clearing pass
// after reset; registration writes an entry before it is ever read.
module tag_keyed_weight_stability_tracker #(
    parameter int TABLE_ENTRIES = tkwst_pkg::TABLE_ENTRIES_DEF,
    parameter int RING_DEPTH    = tkwst_pkg::RING_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [39:0] tag_id, [55:40] weight_grams
    input  logic [tkwst_pkg::IN_DATA_W-1:0]   s_tdata,
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] status, [6:2] slot, [9:7] samples_held, [10] saved,
    // [26:11] stable_grams, [31:27] tags_registered
    output logic [tkwst_pkg::OUT_DATA_W-1:0]  m_tdata,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [tkwst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tkwst_pkg::CFG_W-1:0]       cfg_wdata
);

    localparam int WW  = tkwst_pkg::WEIGHT_W;
    localparam int TW  = tkwst_pkg::TAG_W;
    localparam int AW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW  = $clog2(TABLE_ENTRIES + 1);
    localparam int HW  = $clog2(RING_DEPTH);
    localparam int FW  = $clog2(RING_DEPTH + 1);
    localparam int RING_WORDS = TABLE_ENTRIES * RING_DEPTH;
    localparam int RAW = (RING_WORDS > 1) ? $clog2(RING_WORDS) : 1;
    localparam int MW  = WW + FW + HW;

    localparam logic [CW-1:0]  ENTRIES_C  = CW'(TABLE_ENTRIES);
    localparam logic [FW-1:0]  DEPTH_F    = FW'(RING_DEPTH);
    localparam logic [HW-1:0]  HEAD_LAST  = HW'(RING_DEPTH - 1);
    localparam logic [RAW-1:0] DEPTH_R    = RAW'(RING_DEPTH);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_SEARCH  = 9'b000000010,
        S_META_RD = 9'b000000100,
        S_META_LD = 9'b000001000,
        S_NEW     = 9'b000010000,
        S_RING_WR = 9'b000100000,
        S_CHECK   = 9'b001000000,
        S_SAVE    = 9'b010000000,
        S_FIN     = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Control registers
    logic [CW-1:0]                 count_reg;
    logic [tkwst_pkg::CFG_W-1:0]   thr_reg;
    logic [tkwst_pkg::CFG_W-1:0]   delta_reg;
    logic                          out_valid_reg;

    // Working registers for the transaction in flight
    logic [TW-1:0]                 tag_reg;
    logic [WW-1:0]                 weight_reg;
    logic [CW-1:0]                 rd_idx_reg;
    logic                          pend_reg;
    logic [AW-1:0]                 pend_idx_reg;
    logic [AW-1:0]                 e_reg;
    logic [RAW-1:0]                base_reg;
    logic [HW-1:0]                 head_reg;
    logic [FW-1:0]                 fill_reg;
    logic [WW-1:0]                 stored_reg;
    logic [WW-1:0]                 ref_reg;
    logic [FW-1:0]                 chk_idx_reg;
    logic                          chk_pend_reg;
    logic                          chk_first_reg;
    logic                          stable_reg;
    logic                          saved_reg;
    logic                          full_reg;
    tkwst_pkg::status_t            status_reg;
    logic [tkwst_pkg::OUT_DATA_W-1:0] out_data_reg;

    // Memory ports
    logic [TW-1:0]   tag_rdata;
    logic            tag_we;
    logic [WW-1:0]   ring_rdata;
    logic            ring_we;
    logic [RAW-1:0]  ring_waddr;
    logic [RAW-1:0]  ring_raddr;
    logic [MW-1:0]   meta_rdata;
    logic [MW-1:0]   meta_wdata;
    logic            meta_we;

    // Shared compare unit
    logic [WW-1:0]                 cmp_a;
    logic [WW-1:0]                 cmp_b;
    logic [tkwst_pkg::CFG_W-1:0]   cmp_limit;
    logic                          cmp_above;
    logic                          cmp_reach;

    logic            in_fire;
    logic            out_free;
    logic            hit;
    logic            search_done;
    logic            chk_done;
    logic [HW-1:0]   head_adv;
    logic [FW-1:0]   fill_adv;

    assign in_fire     = s_tvalid && s_tready;
    assign s_tready    = (state_reg == S_IDLE);
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = out_data_reg;
    assign out_free    = !out_valid_reg || m_tready;
    assign hit         = pend_reg && (tag_rdata == tag_reg);
    assign search_done = !pend_reg && (rd_idx_reg >= count_reg);
    assign chk_done    = !chk_pend_reg && (chk_idx_reg == DEPTH_F);
    assign head_adv    = (head_reg == HEAD_LAST) ? '0 : head_reg + 1'b1;
    assign fill_adv    = (fill_reg < DEPTH_F) ? fill_reg + 1'b1 : fill_reg;

    // Steer the shared unit: ring samples against slot 0, or slot 0 against the saved weight
    always_comb
    begin
        if (state_reg == S_CHECK)
        begin
            cmp_a     = ring_rdata;
            cmp_b     = ref_reg;
            cmp_limit = thr_reg;
        end
        else
        begin
            cmp_a     = ref_reg;
            cmp_b     = stored_reg;
            cmp_limit = delta_reg;
        end
    end

    tkwst_absdiff u_absdiff (
        .a     (cmp_a),
        .b     (cmp_b),
        .limit (cmp_limit),
        .above (cmp_above),
        .reach (cmp_reach)
    );

    // Memory controls
    assign tag_we     = (state_reg == S_NEW);
    assign ring_we    = (state_reg == S_RING_WR);
    assign ring_waddr = base_reg + RAW'(head_reg);
    assign ring_raddr = base_reg + RAW'(chk_idx_reg);
    assign meta_we    = (state_reg == S_FIN) && out_free && !full_reg;
    assign meta_wdata = {stored_reg, fill_reg, head_reg};

    tkwst_ram #(
        .WIDTH (TW),
        .DEPTH (TABLE_ENTRIES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (e_reg),
        .wdata (tag_reg),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (tag_rdata)
    );

    tkwst_ram #(
        .WIDTH (WW),
        .DEPTH (RING_WORDS)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (weight_reg),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    tkwst_ram #(
        .WIDTH (MW),
        .DEPTH (TABLE_ENTRIES)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (e_reg),
        .wdata (meta_wdata),
        .raddr (e_reg),
        .rdata (meta_rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (hit)
                begin
                    state_next = S_META_RD;
                end
                else if (search_done)
                begin
                    state_next = (count_reg >= ENTRIES_C) ? S_FIN : S_NEW;
                end
            end
            S_META_RD: state_next = S_META_LD;
            S_META_LD: state_next = S_RING_WR;
            S_NEW:     state_next = S_RING_WR;
            S_RING_WR:
            begin
                state_next = (fill_adv == DEPTH_F) ? S_CHECK : S_FIN;
            end
            S_CHECK:
            begin
                if (chk_done)
                begin
                    state_next = S_SAVE;
                end
            end
            S_SAVE:    state_next = S_FIN;
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Control state, configuration and tag count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            thr_reg       <= tkwst_pkg::STAB_THRESHOLD_RESET;
            delta_reg     <= tkwst_pkg::SAVE_DELTA_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    tkwst_pkg::CFG_STAB_THRESHOLD: thr_reg   <= cfg_wdata;
                    tkwst_pkg::CFG_SAVE_DELTA:     delta_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (state_reg == S_NEW)
            begin
                count_reg <= count_reg + 1'b1;
            end
            // Hold the result until it is taken, load a new one at the finish
            if ((state_reg == S_FIN) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the transaction in flight
    always_ff @(posedge clk)
    begin
        base_reg <= RAW'(e_reg) * DEPTH_R;
        case (state_reg)
            S_IDLE:
            begin
                tag_reg    <= s_tdata[TW-1:0];
                weight_reg <= s_tdata[TW+WW-1:TW];
                rd_idx_reg <= '0;
                pend_reg   <= 1'b0;
                saved_reg  <= 1'b0;
                full_reg   <= 1'b0;
                status_reg <= tkwst_pkg::ST_KNOWN;
            end
            S_SEARCH:
            begin
                // Issue one tag read a cycle, compare the one issued last cycle
                if (hit)
                begin
                    e_reg <= pend_idx_reg;
                end
                else if (search_done)
                begin
                    if (count_reg >= ENTRIES_C)
                    begin
                        full_reg   <= 1'b1;
                        e_reg      <= '0;
                        status_reg <= tkwst_pkg::ST_FULL;
                    end
                    else
                    begin
                        e_reg      <= count_reg[AW-1:0];
                        status_reg <= tkwst_pkg::ST_NEW;
                    end
                end
                else
                begin
                    pend_reg     <= (rd_idx_reg < count_reg);
                    pend_idx_reg <= rd_idx_reg[AW-1:0];
                    if (rd_idx_reg < count_reg)
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                end
            end
            S_META_LD:
            begin
                stored_reg <= meta_rdata[MW-1:FW+HW];
                fill_reg   <= meta_rdata[FW+HW-1:HW];
                head_reg   <= meta_rdata[HW-1:0];
            end
            S_NEW:
            begin
                // Fresh entry: empty ring, nothing saved
                stored_reg <= '0;
                fill_reg   <= '0;
                head_reg   <= '0;
            end
            S_RING_WR:
            begin
                head_reg      <= head_adv;
                fill_reg      <= fill_adv;
                chk_idx_reg   <= '0;
                chk_pend_reg  <= 1'b0;
                chk_first_reg <= 1'b0;
                stable_reg    <= 1'b1;
            end
            S_CHECK:
            begin
                // Slot 0 comes back first and becomes the reference
                if (chk_pend_reg)
                begin
                    if (chk_first_reg)
                    begin
                        ref_reg <= ring_rdata;
                    end
                    else if (cmp_above)
                    begin
                        stable_reg <= 1'b0;
                    end
                end
                if (chk_idx_reg < DEPTH_F)
                begin
                    chk_pend_reg  <= 1'b1;
                    chk_first_reg <= (chk_idx_reg == '0);
                    chk_idx_reg   <= chk_idx_reg + 1'b1;
                end
                else
                begin
                    chk_pend_reg <= 1'b0;
                end
            end
            S_SAVE:
            begin
                if (stable_reg && cmp_reach)
                begin
                    stored_reg <= ref_reg;
                    saved_reg  <= 1'b1;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    if (full_reg)
                    begin
                        out_data_reg <= {5'(count_reg), WW'(0), 1'b0, 3'd0, 5'd0,
                                         status_reg};
                    end
                    else
                    begin
                        out_data_reg <= {5'(count_reg), stored_reg, saved_reg,
                                         3'(fill_reg), 5'(e_reg), status_reg};
                    end
                end
            end
            default: ;
        endcase
    end

endmodule
